// ===== hw/rtl/ctp_pkg.sv =====
package ctp_pkg;

  // Store and key geometry
  localparam int MAX_TEXT  = 64;
  localparam int MAX_KEY   = 8;
  localparam int ADDR_W    = $clog2(MAX_TEXT);
  localparam int CNT_W     = ADDR_W + 1;
  localparam int KEY_IDX_W = $clog2(MAX_KEY);
  localparam int KLEN_W    = 4;
  localparam int KORD_W    = MAX_KEY * KEY_IDX_W;
  localparam int BYTE_W    = 8;

  // Configuration port
  localparam int CFG_W     = KORD_W;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_ORDER = 2'd2;

  localparam logic                MODE_ENCRYPT  = 1'b0;
  localparam logic                MODE_DECRYPT  = 1'b1;
  localparam logic [KLEN_W-1:0]   KEY_LEN_RST   = 4'd1;
  // identity column order 7,6,...,0 packed from entry 7 down to entry 0
  localparam logic [KORD_W-1:0]   KEY_ORDER_RST = 24'hFAC688;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // input byte transfer
    logic div_init;   // final byte: start the row count division
    logic div_step;   // one quotient bit
    logic set_empty;  // no full row: present the empty result
    logic addr_calc;  // work out the store address of the next result
    logic mem_read;   // read the store
    logic advance;    // step the grid counters
    logic finish;     // last result taken: clear for the next message
  } ctp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_last;
    logic rows_zero;
    logic last_item;
  } ctp_status_t;

  // Entry k of the packed key order
  function automatic logic [KEY_IDX_W-1:0] key_entry(input logic [KORD_W-1:0] order,
                                                     input logic [KEY_IDX_W-1:0] k);
    return order[k*KEY_IDX_W +: KEY_IDX_W];
  endfunction

endpackage

// ===== hw/rtl/ctp_ctrl.sv =====
module ctp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 end_of_message_i,
  input  logic                 out_stall_i,
  input  ctp_pkg::ctp_status_t status_i,
  output ctp_pkg::ctp_cmd_t    cmd_o,
  output logic                 in_stall_o,
  output logic                 out_valid_o
);
  import ctp_pkg::*;

  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_SETUP = 3'd2;
  localparam logic [2:0] ST_ADDR  = 3'd3;
  localparam logic [2:0] ST_READ  = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  logic [2:0] state_q, state_d;

  assign in_stall_o  = (state_q != ST_LOAD);
  assign out_valid_o = (state_q == ST_EMIT);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_LOAD: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (end_of_message_i) begin
            cmd_o.div_init = 1'b1;
            state_d        = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) state_d = ST_SETUP;
      end
      ST_SETUP: begin
        if (status_i.rows_zero) begin
          cmd_o.set_empty = 1'b1;
          state_d         = ST_EMIT;
        end else begin
          state_d = ST_ADDR;
        end
      end
      ST_ADDR: begin
        cmd_o.addr_calc = 1'b1;
        state_d         = ST_READ;
      end
      ST_READ: begin
        cmd_o.mem_read = 1'b1;
        state_d        = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_stall_i) begin
          if (status_i.last_item) begin
            cmd_o.finish = 1'b1;
            state_d      = ST_LOAD;
          end else begin
            cmd_o.advance = 1'b1;
            state_d       = ST_ADDR;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/ctp_datapath.sv =====
module ctp_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ctp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ctp_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic [ctp_pkg::BYTE_W-1:0]     text_byte_i,
  input  ctp_pkg::ctp_cmd_t              cmd_i,
  output ctp_pkg::ctp_status_t           status_o,
  output logic [ctp_pkg::BYTE_W-1:0]     out_byte_o,
  output logic                           last_out_o,
  output logic                           overflowed_o,
  output logic                           empty_message_o
);
  import ctp_pkg::*;

  // Configuration registers
  logic                mode_q;
  logic [KLEN_W-1:0]   key_len_q;
  logic [KORD_W-1:0]   key_order_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_ENCRYPT;
      key_len_q   <= KEY_LEN_RST;
      key_order_q <= KEY_ORDER_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODE:      mode_q      <= cfg_wdata_i[0];
        CFG_KEY_LEN:   key_len_q   <= cfg_wdata_i[KLEN_W-1:0];
        CFG_KEY_ORDER: key_order_q <= cfg_wdata_i[KORD_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective key length, clamped to 1..MAX_KEY
  logic [KLEN_W-1:0] kl_eff;
  logic [KLEN_W-1:0] kl_m1;
  always_comb begin
    if (key_len_q == '0) begin
      kl_eff = KLEN_W'(1);
    end else if (key_len_q > KLEN_W'(MAX_KEY)) begin
      kl_eff = KLEN_W'(MAX_KEY);
    end else begin
      kl_eff = key_len_q;
    end
  end
  assign kl_m1 = kl_eff - KLEN_W'(1);

  // Byte count and overflow flag
  logic [CNT_W-1:0] count_q, count_d, count_inc;
  logic             ovf_q, ovf_d;
  logic             full;

  assign full      = (count_q >= CNT_W'(MAX_TEXT));
  assign count_inc = full ? count_q : count_q + CNT_W'(1);

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    if (cmd_i.finish) begin
      count_d = '0;
      ovf_d   = 1'b0;
    end else if (cmd_i.load) begin
      count_d = count_inc;
      if (full) ovf_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  // Text store, one write and one registered read port
  logic [BYTE_W-1:0] mem [MAX_TEXT];
  logic [BYTE_W-1:0] rd_q;
  logic [ADDR_W-1:0] addr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !full) mem[count_q[ADDR_W-1:0]] <= text_byte_i;
    if (cmd_i.mem_read) rd_q <= mem[addr_q];
  end

  // Row count: restoring division of the byte count by the key length
  logic [KEY_IDX_W-1:0] div_rem_q;
  logic [CNT_W-1:0]     div_quo_q;
  logic [2:0]           div_cnt_q;
  logic [KLEN_W-1:0]    div_trial;
  logic                 div_ge;
  logic [KLEN_W-1:0]    div_diff;

  assign div_trial = {div_rem_q, div_quo_q[CNT_W-1]};
  assign div_ge    = (div_trial >= kl_eff);
  assign div_diff  = div_trial - kl_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_rem_q <= '0;
      div_quo_q <= '0;
      div_cnt_q <= '0;
    end else if (cmd_i.div_init) begin
      div_rem_q <= '0;
      div_quo_q <= count_inc;
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      div_rem_q <= div_ge ? div_diff[KEY_IDX_W-1:0] : div_trial[KEY_IDX_W-1:0];
      div_quo_q <= {div_quo_q[CNT_W-2:0], div_ge};
      div_cnt_q <= div_cnt_q + 3'd1;
    end
  end

  // Grid walk: encrypt goes key entry (outer) by row (inner),
  // decrypt goes row (outer) by column (inner)
  logic [CNT_W-1:0]  rows;
  logic [CNT_W-1:0]  rows_m1;
  logic [ADDR_W-1:0] inner_q, outer_q;
  logic [CNT_W-1:0]  base_q;
  logic [ADDR_W-1:0] inner_lim, outer_lim;
  logic              inner_end;

  assign rows      = div_quo_q;
  assign rows_m1   = rows - CNT_W'(1);
  assign inner_lim = (mode_q == MODE_ENCRYPT) ? rows_m1[ADDR_W-1:0] : ADDR_W'(kl_m1);
  assign outer_lim = (mode_q == MODE_ENCRYPT) ? ADDR_W'(kl_m1) : rows_m1[ADDR_W-1:0];
  assign inner_end = (inner_q == inner_lim);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inner_q <= '0;
      outer_q <= '0;
      base_q  <= '0;
    end else if (cmd_i.div_init) begin
      inner_q <= '0;
      outer_q <= '0;
      base_q  <= '0;
    end else if (cmd_i.advance) begin
      if (inner_end) begin
        inner_q <= '0;
        base_q  <= '0;
        outer_q <= outer_q + ADDR_W'(1);
      end else begin
        inner_q <= inner_q + ADDR_W'(1);
        base_q  <= base_q + CNT_W'(kl_eff);
      end
    end
  end

  // Encrypt address: row base plus keyed column, past the count reads zero
  logic [KEY_IDX_W-1:0] enc_col;
  logic [CNT_W-1:0]     enc_idx;
  logic                 enc_zero;

  assign enc_col  = key_entry(key_order_q, outer_q[KEY_IDX_W-1:0]);
  assign enc_idx  = base_q + CNT_W'(enc_col);
  assign enc_zero = (enc_idx >= count_q);

  // Decrypt: last key entry naming this column gives the source run
  logic                 dec_found;
  logic [KEY_IDX_W-1:0] dec_m;
  logic [9:0]           dec_idx;

  always_comb begin
    dec_found = 1'b0;
    dec_m     = '0;
    for (int m = 0; m < MAX_KEY; m++) begin
      if ((KLEN_W'(m) < kl_eff) &&
          (key_entry(key_order_q, KEY_IDX_W'(m)) == inner_q[KEY_IDX_W-1:0])) begin
        dec_found = 1'b1;
        dec_m     = KEY_IDX_W'(m);
      end
    end
  end

  assign dec_idx = 10'(dec_m) * 10'(rows) + 10'(outer_q);

  // Result registers
  logic zero_q, last_q, empty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q  <= '0;
      zero_q  <= 1'b1;
      last_q  <= 1'b0;
      empty_q <= 1'b0;
    end else if (cmd_i.set_empty) begin
      zero_q  <= 1'b1;
      last_q  <= 1'b1;
      empty_q <= 1'b1;
    end else if (cmd_i.addr_calc) begin
      if (mode_q == MODE_ENCRYPT) begin
        addr_q <= enc_idx[ADDR_W-1:0];
        zero_q <= enc_zero;
      end else begin
        addr_q <= dec_idx[ADDR_W-1:0];
        zero_q <= !dec_found;
      end
      last_q  <= inner_end && (outer_q == outer_lim);
      empty_q <= 1'b0;
    end
  end

  assign out_byte_o      = zero_q ? '0 : rd_q;
  assign last_out_o      = last_q;
  assign overflowed_o    = ovf_q;
  assign empty_message_o = empty_q;

  assign status_o.div_last  = (div_cnt_q == 3'(CNT_W - 1));
  assign status_o.rows_zero = (rows == '0);
  assign status_o.last_item = last_q;

endmodule

// ===== hw/rtl/columnar_transposition_cipher_core.sv =====
// Channel   Direction  Handshake               Payload
// in        sink       in_valid_i / in_stall_o   text_byte_i, end_of_message_i
// out       source     out_valid_o / out_stall_i out_byte_o, last_out_o,
//                                                overflowed_o, empty_message_o
// cfg       sink       cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// Message bytes load at one per cycle into a 64-byte store while the input is not stalled.
// After the final byte, the row count comes from a 7-step shift-subtract
// division by the key length, then a setup state; each result but the empty
// one then passes through address calculation, store read and presentation.
// Input is stalled from the final byte until the last result is transferred.
// Reset returns the registers to encrypt, key length 1, identity order.
// An output stall holds the presented result unchanged.
module columnar_transposition_cipher_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ctp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ctp_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [ctp_pkg::BYTE_W-1:0]     text_byte_i,
  input  logic                           end_of_message_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [ctp_pkg::BYTE_W-1:0]     out_byte_o,
  output logic                           last_out_o,
  output logic                           overflowed_o,
  output logic                           empty_message_o
);
  import ctp_pkg::*;

  ctp_cmd_t    cmd;
  ctp_status_t status;

  ctp_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .end_of_message_i (end_of_message_i),
    .out_stall_i      (out_stall_i),
    .status_i         (status),
    .cmd_o            (cmd),
    .in_stall_o       (in_stall_o),
    .out_valid_o      (out_valid_o)
  );

  ctp_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .text_byte_i     (text_byte_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_byte_o      (out_byte_o),
    .last_out_o      (last_out_o),
    .overflowed_o    (overflowed_o),
    .empty_message_o (empty_message_o)
  );

endmodule

// ===== hw/rtl/ctp_checker.sv =====
module ctp_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           end_of_message_i,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [ctp_pkg::BYTE_W-1:0]     out_byte_o,
  input logic                           last_out_o,
  input logic                           empty_message_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o) && $stable(last_out_o))
    else $error("stalled result changed");

  // No input is taken while a result is presented
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken during result burst");

  // The empty result is a single zero byte closing the message
  a_empty_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && empty_message_o |-> last_out_o && (out_byte_o == '0))
    else $error("malformed empty result");

  // Final byte closes the input side until the burst is done
  a_eom_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && end_of_message_i |=> in_stall_o)
    else $error("input open after final byte");

  // After the last result transfer the block goes back to loading
  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && last_out_o |=> !out_valid_o && !in_stall_o)
    else $error("burst did not end on last result");

endmodule

bind columnar_transposition_cipher_core ctp_checker u_ctp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .end_of_message_i (end_of_message_i),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .out_byte_o       (out_byte_o),
  .last_out_o       (last_out_o),
  .empty_message_o  (empty_message_o)
);

// ===== verif/tb_columnar_transposition_cipher_core.sv =====
`timescale 1ns / 1ps

module tb_columnar_transposition_cipher_core;
  import ctp_pkg::*;

  // Index past the register list: the block must ignore writes to it
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  // Settling time after the last result: return to loading and clear
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_ITEMS  = 220;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              ovf;
    logic              empty;
  } cipher_out_t;

  logic                 clk_i            = 1'b0;
  logic                 rst_ni           = 1'b0;
  logic                 cfg_we_i         = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i        = '0;
  logic [CFG_W-1:0]     cfg_wdata_i      = '0;
  logic                 in_valid_i       = 1'b0;
  logic                 in_stall_o;
  logic [BYTE_W-1:0]    text_byte_i      = '0;
  logic                 end_of_message_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i      = 1'b0;
  logic [BYTE_W-1:0]    out_byte_o;
  logic                 last_out_o;
  logic                 overflowed_o;
  logic                 empty_message_o;

  // Predictor state: registers and the message held so far
  logic              mode_q;
  logic [KLEN_W-1:0] key_len_q;
  logic [KORD_W-1:0] key_order_q;
  logic [BYTE_W-1:0] msg_store [MAX_TEXT];
  int unsigned       msg_len;
  logic              msg_dropped;

  cipher_out_t transposed_q[$];
  int          mismatches    = 0;
  int          items_sent    = 0;
  int          in_gap_pct    = 7;
  int          out_stall_pct = 7;

  columnar_transposition_cipher_core u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .text_byte_i      (text_byte_i),
    .end_of_message_i (end_of_message_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_byte_o       (out_byte_o),
    .last_out_o       (last_out_o),
    .overflowed_o     (overflowed_o),
    .empty_message_o  (empty_message_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Key length as the block uses it: 0 counts as 1, anything above 8 as 8
  function automatic int unsigned column_count();
    if (key_len_q < 1) return 1;
    if (key_len_q > MAX_KEY) return MAX_KEY;
    return key_len_q;
  endfunction

  function automatic int unsigned key_column(input int unsigned k);
    return key_order_q[KEY_IDX_W*k +: KEY_IDX_W];
  endfunction

  // Positions past the stored count read as zero
  function automatic logic [BYTE_W-1:0] held_byte(input int unsigned idx);
    return (idx < msg_len) ? msg_store[idx] : '0;
  endfunction

  // Final byte taken: queue the whole transposed burst, then clear the message
  task automatic predict_transposition();
    logic [BYTE_W-1:0] grid [MAX_TEXT];
    logic [BYTE_W-1:0] cols [MAX_TEXT];
    int unsigned       k, rows, total, n, col, dst;
    cipher_out_t       res;
    k     = column_count();
    rows  = msg_len / k;
    total = rows * k;
    n     = 0;
    if (rows == 0) begin
      res = '{data: '0, last: 1'b1, ovf: msg_dropped, empty: 1'b1};
      transposed_q.push_back(res);
    end else begin
      if (mode_q == MODE_ENCRYPT) begin
        // columns in key order, each read top to bottom
        for (int unsigned i = 0; i < k; i++) begin
          col = key_column(i);
          for (int unsigned j = 0; j < rows; j++) begin
            grid[n] = held_byte(j * k + col);
            n++;
          end
        end
      end else begin
        // refill columns from runs of input, later writes win, then read rows
        for (int unsigned i = 0; i < MAX_TEXT; i++) cols[i] = '0;
        for (int unsigned m = 0; m < k; m++) begin
          col = key_column(m);
          for (int unsigned j = 0; j < rows; j++) begin
            dst = col * rows + j;
            if (dst < total) cols[dst] = held_byte(m * rows + j);
          end
        end
        for (int unsigned i = 0; i < rows; i++) begin
          for (int unsigned j = 0; j < k; j++) begin
            grid[n] = cols[j * rows + i];
            n++;
          end
        end
      end
      for (int unsigned i = 0; i < n; i++) begin
        res = '{data: grid[i], last: (i + 1 == n), ovf: msg_dropped, empty: 1'b0};
        transposed_q.push_back(res);
      end
    end
    msg_len     = 0;
    msg_dropped = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // One input transfer; valid is left high for a following byte
  task automatic push_byte(input logic [BYTE_W-1:0] value, input logic eom);
    while ($urandom_range(99) < in_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    text_byte_i      <= value;
    end_of_message_i <= eom;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    if (msg_len < MAX_TEXT) begin
      msg_store[msg_len] = value;
      msg_len++;
    end else begin
      msg_dropped = 1'b1;
    end
    if (eom) predict_transposition();
  endtask

  task automatic send_message(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) push_byte(BYTE_W'($urandom), i + 1 == len);
  endtask

  // Stop sending and wait for the block to go idle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (transposed_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_MODE:      mode_q      = value[0];
      CFG_KEY_LEN:   key_len_q   = value[KLEN_W-1:0];
      CFG_KEY_ORDER: key_order_q = value;
      default: ;
    endcase
  endtask

  // Unused upper data bits carry noise; the block must mask them
  task automatic set_config(input logic mode, input logic [KLEN_W-1:0] klen,
                            input logic [KORD_W-1:0] order);
    logic [CFG_W-1:0] word;
    word    = CFG_W'($urandom);
    word[0] = mode;
    write_reg(CFG_MODE, word);
    word             = CFG_W'($urandom);
    word[KLEN_W-1:0] = klen;
    write_reg(CFG_KEY_LEN, word);
    write_reg(CFG_KEY_ORDER, order);
  endtask

  // First k entries a shuffle of 0..k-1, the rest noise
  function automatic logic [KORD_W-1:0] shuffled_key(input int unsigned k);
    logic [KORD_W-1:0] order;
    int                perm [MAX_KEY];
    int                j, tmp;
    order = KORD_W'($urandom);
    for (int i = 0; i < MAX_KEY; i++) perm[i] = i;
    for (int i = int'(k) - 1; i > 0; i--) begin
      j       = $urandom_range(i);
      tmp     = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    for (int i = 0; i < int'(k); i++) order[KEY_IDX_W*i +: KEY_IDX_W] = perm[i][KEY_IDX_W-1:0];
    return order;
  endfunction

  always @(posedge clk_i) out_stall_i <= ($urandom_range(99) < out_stall_pct);

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input logic [BYTE_W-1:0] got,
                               input logic [BYTE_W-1:0] want);
    if (got !== want) report_mismatch($sformatf("%s: got %0h, expected %0h", name, got, want));
  endtask

  always @(posedge clk_i) begin
    cipher_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (transposed_q.size() == 0) begin
        report_mismatch($sformatf("result %0h with none expected", out_byte_o));
      end else begin
        want = transposed_q.pop_front();
        compare_field("out_byte", out_byte_o, want.data);
        compare_field("last_out", BYTE_W'(last_out_o), BYTE_W'(want.last));
        compare_field("overflowed", BYTE_W'(overflowed_o), BYTE_W'(want.ovf));
        compare_field("empty_message", BYTE_W'(empty_message_o), BYTE_W'(want.empty));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset registers (encrypt, one column); a write past the list changes nothing
  task automatic test_reset_config();
    write_reg(CFG_UNUSED, CFG_W'($urandom));
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    drain();
  endtask

  // Fewer bytes than one row
  task automatic test_empty_message();
    set_config(MODE_ENCRYPT, 4'd3, shuffled_key(3));
    send_message(2);
    drain();
  endtask

  // Key 2,0,1 with a part row dropped, then a key entry past the columns
  task automatic test_encrypt();
    set_config(MODE_ENCRYPT, 4'd3, 24'hFFFE42);
    send_message(5);
    drain();
    set_config(MODE_ENCRYPT, 4'd2, 24'h000028);
    send_message(3);
    drain();
  endtask

  // Inverse of the same key, then a key whose entries all fall outside the grid
  task automatic test_decrypt();
    set_config(MODE_DECRYPT, 4'd3, 24'hFFFE42);
    send_message(6);
    drain();
    set_config(MODE_DECRYPT, 4'd2, 24'hFFFFFF);
    send_message(2);
    drain();
  endtask

  // Key length 0 acts as 1, 15 acts as 8
  task automatic test_key_length_clamp();
    set_config(MODE_ENCRYPT, 4'd0, 24'h000000);
    send_message(1);
    drain();
    set_config(MODE_DECRYPT, 4'd15, shuffled_key(MAX_KEY));
    send_message(8);
    drain();
  endtask

  // More bytes than the store holds, the final one among those dropped
  task automatic test_store_overflow();
    set_config(MODE_ENCRYPT, 4'(MAX_KEY), shuffled_key(MAX_KEY));
    send_message(MAX_TEXT + 2);
    drain();
  endtask

  task automatic test_random_messages();
    int          stop_at, calm_from, calm_to, r, msgs;
    logic [KLEN_W-1:0] klen;
    logic [KORD_W-1:0] order;
    int unsigned eff, len;
    stop_at   = items_sent + RANDOM_ITEMS;
    calm_from = items_sent + RANDOM_ITEMS / 3;
    calm_to   = items_sent + 2 * RANDOM_ITEMS / 3;
    while (items_sent < stop_at) begin
      // middle third runs without gaps or stalls
      if (items_sent >= calm_from && items_sent < calm_to) begin
        in_gap_pct    = 0;
        out_stall_pct = 0;
      end else begin
        in_gap_pct    = 7;
        out_stall_pct = 7;
      end
      r    = $urandom_range(99);
      klen = (r < 10) ? KLEN_W'($urandom) : KLEN_W'($urandom_range(1, MAX_KEY));
      eff  = (klen < 1) ? 1 : (klen > MAX_KEY) ? MAX_KEY : klen;
      r    = $urandom_range(99);
      if (r < 12)      order = KORD_W'($urandom);
      else if (r < 16) order = '0;
      else if (r < 20) order = '1;
      else             order = shuffled_key(eff);
      set_config(1'($urandom), klen, order);
      if ($urandom_range(9) == 0) write_reg(CFG_UNUSED, CFG_W'($urandom));
      msgs = $urandom_range(1, 3);
      for (int i = 0; i < msgs; i++) begin
        r = $urandom_range(99);
        if (r < 6)       len = $urandom_range(MAX_TEXT - 4, MAX_TEXT + 6);
        else if (r < 20) len = $urandom_range(1, 3);
        else             len = $urandom_range(1, 24);
        send_message(len);
      end
      drain();
    end
    in_gap_pct    = 7;
    out_stall_pct = 7;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    mode_q      = MODE_ENCRYPT;
    key_len_q   = KEY_LEN_RST;
    key_order_q = KEY_ORDER_RST;
    msg_len     = 0;
    msg_dropped = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_config();
    test_empty_message();
    test_encrypt();
    test_decrypt();
    test_key_length_clamp();
    test_store_overflow();
    test_random_messages();
    drain();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
